FILE: src/meter_frame_deframer_top_assert.svh
// ----------------------------------------------------------------------------
// Meter frame deframer assertion macros
// Shared concurrent assertion forms for the deframer checkers.
// ----------------------------------------------------------------------------
`ifndef METER_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define METER_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define MFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define MFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

FILE: src/mfd_pkg.sv
// ----------------------------------------------------------------------------
// Meter frame deframer package
// Frame markers, result kinds, status codes and phase codes.
// ----------------------------------------------------------------------------
package mfd_pkg;

  typedef logic [3:0] phase_t;
  typedef logic [2:0] kind_t;
  typedef logic [2:0] status_t;

  localparam logic [7:0] START_MARK = 8'h68;
  localparam logic [7:0] END_MARK   = 8'h16;
  localparam logic [7:0] PRE_MARK   = 8'hFE;
  localparam logic [7:0] DATA_BIAS  = 8'h33;
  localparam logic [2:0] ADDR_FIELD_LEN = 3'd6;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam kind_t KIND_ADDR   = 3'd0;
  localparam kind_t KIND_CTRL   = 3'd1;
  localparam kind_t KIND_LEN    = 3'd2;
  localparam kind_t KIND_DATA   = 3'd3;
  localparam kind_t KIND_STATUS = 3'd4;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_BAD_START = 3'd1;
  localparam status_t ST_BAD_START2 = 3'd2;
  localparam status_t ST_CHECKSUM  = 3'd3;
  localparam status_t ST_BAD_END   = 3'd4;
  localparam status_t ST_TRUNCATED = 3'd5;

  localparam phase_t PH_HUNT   = 4'd0;
  localparam phase_t PH_ADDR   = 4'd1;
  localparam phase_t PH_START2 = 4'd2;
  localparam phase_t PH_CTRL   = 4'd3;
  localparam phase_t PH_LEN    = 4'd4;
  localparam phase_t PH_DATA   = 4'd5;
  localparam phase_t PH_CSUM   = 4'd6;
  localparam phase_t PH_END    = 4'd7;
  localparam phase_t PH_IGNORE = 4'd8;

endpackage

FILE: src/meter_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// Meter frame deframer
// Decodes a meter frame from a byte stream, emitting fields and one status.
// ----------------------------------------------------------------------------
// Channel   Direction  Request contents
// in_*      slave      one received byte, tlast marks the buffer end
// out_*     master     one frame field or the frame status
//
// Each byte passes through the phase decoder into the output register,
// so a byte can be taken in every cycle while out_tready is high.
// Reset is synchronous and active low and returns the decoder to preamble
// hunting. A stalled output request holds in_tready low until it is taken.
// ----------------------------------------------------------------------------
module meter_frame_deframer_top
  import mfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tlast,   // buffer_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] item_value, [10:8] status_code,
                                  // [26:11] bytes_consumed, [31:27] zero
  output logic [2:0]  out_tuser,  // [2:0] item_kind
  output logic        out_tlast   // frame_last
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  addr_idx_r, addr_idx_nxt;
  logic [7:0]  data_rem_r, data_rem_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] count_inc;

  logic        out_valid_r;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  value_r, value_nxt;
  status_t     code_r, code_nxt;
  logic [15:0] cons_r;
  logic        last_r;

  logic        emit;
  logic        do_status;
  logic        accept;
  logic [7:0]  rx;
  logic        buf_end;

  assign rx        = in_tdata;
  assign buf_end   = in_tlast;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 16'd1;

  always_comb begin
    phase_nxt    = phase_r;
    addr_idx_nxt = addr_idx_r;
    data_rem_nxt = data_rem_r;
    sum_nxt      = sum_r;
    count_nxt    = count_r;
    emit         = 1'b0;
    do_status    = 1'b0;
    kind_nxt     = KIND_ADDR;
    value_nxt    = 8'd0;
    code_nxt     = ST_OK;
    if (phase_r >= PH_IGNORE) begin
      if (buf_end) begin
        phase_nxt    = PH_HUNT;
        addr_idx_nxt = 3'd0;
        data_rem_nxt = 8'd0;
        sum_nxt      = 8'd0;
        count_nxt    = 16'd0;
      end
    end else begin
      count_nxt = count_inc;
      if (buf_end && phase_r != PH_END) begin
        do_status = 1'b1;
        code_nxt  = ST_TRUNCATED;
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
            if (rx != PRE_MARK) begin
              if (rx != START_MARK) begin
                do_status = 1'b1;
                code_nxt  = ST_BAD_START;
              end else begin
                sum_nxt      = rx;
                addr_idx_nxt = 3'd0;
                phase_nxt    = PH_ADDR;
              end
            end
          end
          PH_ADDR: begin
            sum_nxt      = sum_r + rx;
            addr_idx_nxt = addr_idx_r + 3'd1;
            if (addr_idx_nxt >= ADDR_FIELD_LEN) begin
              phase_nxt = PH_START2;
            end
            emit      = 1'b1;
            kind_nxt  = KIND_ADDR;
            value_nxt = rx;
          end
          PH_START2: begin
            if (rx != START_MARK) begin
              do_status = 1'b1;
              code_nxt  = ST_BAD_START2;
            end else begin
              sum_nxt   = sum_r + rx;
              phase_nxt = PH_CTRL;
            end
          end
          PH_CTRL: begin
            sum_nxt   = sum_r + rx;
            phase_nxt = PH_LEN;
            emit      = 1'b1;
            kind_nxt  = KIND_CTRL;
            value_nxt = rx;
          end
          PH_LEN: begin
            sum_nxt      = sum_r + rx;
            data_rem_nxt = rx;
            phase_nxt    = (rx != 8'd0) ? PH_DATA : PH_CSUM;
            emit         = 1'b1;
            kind_nxt     = KIND_LEN;
            value_nxt    = rx;
          end
          PH_DATA: begin
            sum_nxt      = sum_r + rx;
            data_rem_nxt = data_rem_r - 8'd1;
            if (data_rem_nxt == 8'd0) begin
              phase_nxt = PH_CSUM;
            end
            emit      = 1'b1;
            kind_nxt  = KIND_DATA;
            value_nxt = rx - DATA_BIAS;
          end
          PH_CSUM: begin
            if (rx != sum_r) begin
              do_status = 1'b1;
              code_nxt  = ST_CHECKSUM;
            end else begin
              phase_nxt = PH_END;
            end
          end
          PH_END: begin
            do_status = 1'b1;
            code_nxt  = (rx == END_MARK) ? ST_OK : ST_BAD_END;
          end
          default: begin
          end
        endcase
      end
      if (do_status) begin
        emit      = 1'b1;
        kind_nxt  = KIND_STATUS;
        value_nxt = 8'd0;
        if (buf_end) begin
          phase_nxt    = PH_HUNT;
          addr_idx_nxt = 3'd0;
          data_rem_nxt = 8'd0;
          sum_nxt      = 8'd0;
          count_nxt    = 16'd0;
        end else begin
          phase_nxt = PH_IGNORE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      addr_idx_r  <= 3'd0;
      data_rem_r  <= 8'd0;
      sum_r       <= 8'd0;
      count_r     <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        addr_idx_r  <= addr_idx_nxt;
        data_rem_r  <= data_rem_nxt;
        sum_r       <= sum_nxt;
        count_r     <= count_nxt;
        out_valid_r <= emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
      code_r  <= code_nxt;
      cons_r  <= do_status ? count_inc : 16'd0;
      last_r  <= do_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, cons_r, code_r, value_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

FILE: src/mfd_checker.sv
// ----------------------------------------------------------------------------
// Meter frame deframer checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "meter_frame_deframer_top_assert.svh"

module mfd_checker
  import mfd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  `MFD_ASSERT_NOW(a_last_marks_status, out_tvalid, out_tlast == (out_tuser == KIND_STATUS))
  `MFD_ASSERT_NOW(a_field_clean, out_tvalid && !out_tlast, out_tdata[31:8] == 24'd0)
  `MFD_ASSERT_NOW(a_status_form, out_tvalid && out_tlast,
                  out_tdata[7:0] == 8'd0 && out_tdata[26:11] != 16'd0 &&
                  out_tdata[10:8] <= ST_TRUNCATED)
  `MFD_ASSERT_NEXT(a_stall_holds, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `MFD_ASSERT_NOW(a_stall_blocks_in, out_tvalid && !out_tready, !in_tready)

endmodule

bind meter_frame_deframer_top mfd_checker u_mfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
